// ===== hdl/tccw_pkg.sv =====
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types and constants for the text console character writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

  // fixed field widths of the request and result channels
  localparam int ACTION_W = 2;
  localparam int CHAR_W   = 8;
  localparam int COLOR_W  = 8;
  localparam int RROW_W   = 5;
  localparam int RCOL_W   = 7;
  localparam int OCOL_W   = 7;
  localparam int OROW_W   = 5;
  localparam int LIN_W    = 11;

  // request actions
  typedef enum logic [ACTION_W-1:0] {
    ACT_PUT   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_BACK  = 2'd2,
    ACT_READ  = 2'd3
  } act_t;

  // control characters
  localparam logic [CHAR_W-1:0] CH_NULL    = 8'd0;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

  localparam logic [COLOR_W-1:0] BLANK_COLOR_RST = 8'h07;

  typedef enum logic [1:0] {
    CC_PLAIN   = 2'd0,
    CC_NEWLINE = 2'd1,
    CC_RETURN  = 2'd2,
    CC_TAB     = 2'd3
  } chr_class_t;

  typedef enum logic [2:0] {
    CUR_HOLD      = 3'd0,
    CUR_NEXT_COL  = 3'd1,
    CUR_NEXT_LINE = 3'd2,
    CUR_RETURN    = 3'd3,
    CUR_BACK      = 3'd4,
    CUR_HOME      = 3'd5
  } cur_op_t;

  typedef enum logic [2:0] {
    WR_NONE       = 3'd0,
    WR_REQ_CHAR   = 3'd1,
    WR_SPACE_CHAR = 3'd2,
    WR_NL_CELL    = 3'd3,
    WR_ZERO_LEFT  = 3'd4
  } wr_op_t;

  typedef enum logic {
    SW_CLEAR  = 1'b0,
    SW_SCROLL = 1'b1
  } sweep_mode_t;

  // controller to datapath
  typedef struct packed {
    logic        in_ready;
    cur_op_t     cur_op;
    wr_op_t      wr_op;
    logic        tab_load;
    logic        tab_dec;
    logic        sweep_start;
    sweep_mode_t sweep_mode;
    logic        sweep_run;
    logic        rd_issue;
    logic        out_load;
  } tccw_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       in_valid;
    act_t       act;
    chr_class_t chr;
    logic       col_zero;
    logic       col_last;
    logic       row_last;
    logic       rd_in_range;
    logic       tab_zero;
    logic       tab_last;
    logic       sweep_last;
    logic       out_free;
  } tccw_sts_t;

endpackage

// ===== hdl/tccw_req_if.sv =====
// ----------------------------------------------------------------------------
// tccw_req_if
// Request channel: valid/ready handshake with the console action payload.
// ----------------------------------------------------------------------------
interface tccw_req_if import tccw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [CHAR_W-1:0]   char_code;
  logic [RROW_W-1:0]   read_row;
  logic [RCOL_W-1:0]   read_col;

  modport source (output valid, output action, output char_code, output read_row,
                  output read_col, input ready);
  modport sink   (input valid, input action, input char_code, input read_row,
                  input read_col, output ready);
endinterface

// ===== hdl/tccw_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tccw_rsp_if
// Result channel: valid/ready handshake with cursor and read cell payload.
// ----------------------------------------------------------------------------
interface tccw_rsp_if import tccw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OCOL_W-1:0]  cursor_col;
  logic [OROW_W-1:0]  cursor_row;
  logic [LIN_W-1:0]   cursor_linear;
  logic [CHAR_W-1:0]  cell_char;
  logic [COLOR_W-1:0] cell_color;

  modport source (output valid, output cursor_col, output cursor_row,
                  output cursor_linear, output cell_char, output cell_color,
                  input ready);
  modport sink   (input valid, input cursor_col, input cursor_row,
                  input cursor_linear, input cell_char, input cell_color,
                  output ready);
endinterface

// ===== hdl/tccw_datapath.sv =====
// ----------------------------------------------------------------------------
// tccw_datapath
// Cell memories, cursor, tab counter, sweep pipeline and result register.
// ----------------------------------------------------------------------------
module tccw_datapath import tccw_pkg::*; #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [COLOR_W-1:0] cfg_wr_data,
  tccw_req_if.sink           in_chan,
  tccw_rsp_if.source         out_chan,
  input  tccw_cmd_t          cmd_i,
  output tccw_sts_t          sts_o
);

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int PH_W   = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
  localparam int TC_W   = $clog2(TAB_STOP + 1);

  // request capture
  act_t              req_act_r;
  logic [CHAR_W-1:0] req_char_r;
  logic [RROW_W-1:0] req_row_r;
  logic [RCOL_W-1:0] req_col_r;
  logic              accept;

  // cursor and tab state
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [PH_W-1:0]  phase_r, phase_nxt;
  logic [TC_W-1:0]  tab_cnt_r, tab_cnt_nxt;
  logic [COLOR_W-1:0] color_r;

  // sweep pipeline
  logic [ADDR_W-1:0] sweep_r, sweep_nxt;
  sweep_mode_t       sweep_mode_r;
  logic              sw_wr_r;
  logic [ADDR_W-1:0] sw_addr_r;
  logic              sw_fill_r;
  logic              sw_copy;
  logic [ADDR_W-1:0] copy_addr;

  // memories
  logic [CHAR_W-1:0]  char_mem  [CELLS];
  logic [COLOR_W-1:0] color_mem [CELLS];
  logic [CHAR_W-1:0]  rd_char_r;
  logic [COLOR_W-1:0] rd_color_r;
  logic               rd_hit_r;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ADDR_W-1:0]  rd_req_addr;
  logic               wr_char_en;
  logic               wr_color_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [CHAR_W-1:0]  wr_char;
  logic [COLOR_W-1:0] wr_color;

  logic [ADDR_W-1:0]        cur_addr;
  logic [ADDR_W+LIN_W-1:0]  lin_ext;
  logic [COL_W+OCOL_W-1:0]  col_ext;
  logic [ROW_W+OROW_W-1:0]  row_ext;
  logic                     col_last;
  logic                     row_last;
  chr_class_t               chr;

  // result register
  logic               out_valid_r;
  logic [OCOL_W-1:0]  out_col_r;
  logic [OROW_W-1:0]  out_row_r;
  logic [LIN_W-1:0]   out_lin_r;
  logic [CHAR_W-1:0]  out_char_r;
  logic [COLOR_W-1:0] out_color_r;

  assign accept        = in_chan.valid && cmd_i.in_ready;
  assign in_chan.ready = cmd_i.in_ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      req_act_r  <= act_t'(in_chan.action);
      req_char_r <= in_chan.char_code;
      req_row_r  <= in_chan.read_row;
      req_col_r  <= in_chan.read_col;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r <= BLANK_COLOR_RST;
    end else if (cfg_wr_en) begin
      color_r <= cfg_wr_data;
    end
  end

  always_comb begin
    unique case (req_char_r)
      CH_NEWLINE: chr = CC_NEWLINE;
      CH_RETURN:  chr = CC_RETURN;
      CH_TAB:     chr = CC_TAB;
      default:    chr = CC_PLAIN;
    endcase
  end

  assign cur_addr    = ADDR_W'(row_r) * ADDR_W'(COLUMNS) + ADDR_W'(col_r);
  assign rd_req_addr = ADDR_W'(req_row_r) * ADDR_W'(COLUMNS) + ADDR_W'(req_col_r);
  assign col_last    = (col_r == COL_W'(COLUMNS - 1));
  assign row_last    = (row_r == ROW_W'(ROWS - 1));

  // cursor moves, tab phase follows the column modulo the tab stop
  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    phase_nxt = phase_r;
    unique case (cmd_i.cur_op)
      CUR_HOLD: begin
      end
      CUR_NEXT_COL: begin
        col_nxt   = col_r + 1'b1;
        phase_nxt = (phase_r == PH_W'(TAB_STOP - 1)) ? '0 : phase_r + 1'b1;
      end
      CUR_NEXT_LINE: begin
        col_nxt   = '0;
        row_nxt   = row_last ? row_r : row_r + 1'b1;
        phase_nxt = '0;
      end
      CUR_RETURN: begin
        col_nxt   = '0;
        phase_nxt = '0;
      end
      CUR_BACK: begin
        col_nxt   = col_r - 1'b1;
        phase_nxt = (phase_r == '0) ? PH_W'(TAB_STOP - 1) : phase_r - 1'b1;
      end
      CUR_HOME: begin
        col_nxt   = '0;
        row_nxt   = '0;
        phase_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    tab_cnt_nxt = tab_cnt_r;
    if (cmd_i.tab_load) begin
      tab_cnt_nxt = TC_W'(TAB_STOP) - TC_W'(phase_r);
    end else if (cmd_i.tab_dec) begin
      tab_cnt_nxt = tab_cnt_r - 1'b1;
    end
  end

  always_comb begin
    sweep_nxt = sweep_r;
    if (cmd_i.sweep_start) begin
      sweep_nxt = '0;
    end else if (cmd_i.sweep_run) begin
      sweep_nxt = sweep_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      phase_r   <= '0;
      tab_cnt_r <= '0;
      sweep_r   <= '0;
      sw_wr_r   <= 1'b0;
    end else begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      phase_r   <= phase_nxt;
      tab_cnt_r <= tab_cnt_nxt;
      sweep_r   <= sweep_nxt;
      sw_wr_r   <= cmd_i.sweep_run;
    end
  end

  // scroll copies cell k+COLUMNS down to k, the tail of the sweep fills
  assign sw_copy   = (sweep_mode_r == SW_SCROLL) && (32'(sweep_r) < CELLS - COLUMNS);
  assign copy_addr = sweep_r + ADDR_W'(COLUMNS);

  always_ff @(posedge clk) begin
    if (cmd_i.sweep_start) begin
      sweep_mode_r <= cmd_i.sweep_mode;
    end
    if (cmd_i.sweep_run) begin
      sw_addr_r <= sweep_r;
      sw_fill_r <= !sw_copy;
    end
  end

  assign rd_en   = cmd_i.rd_issue || (cmd_i.sweep_run && sw_copy);
  assign rd_addr = cmd_i.rd_issue ? rd_req_addr : copy_addr;

  always_comb begin
    wr_char_en  = 1'b0;
    wr_color_en = 1'b0;
    wr_addr     = cur_addr;
    wr_char     = CH_NULL;
    wr_color    = color_r;
    if (sw_wr_r) begin
      wr_char_en  = 1'b1;
      wr_color_en = 1'b1;
      wr_addr     = sw_addr_r;
      if (!sw_fill_r) begin
        wr_char  = rd_char_r;
        wr_color = rd_color_r;
      end
    end else begin
      unique case (cmd_i.wr_op)
        WR_NONE: begin
        end
        WR_REQ_CHAR: begin
          wr_char_en = 1'b1;
          wr_char    = req_char_r;
        end
        WR_SPACE_CHAR: begin
          wr_char_en = 1'b1;
          wr_char    = CH_SPACE;
        end
        WR_NL_CELL: begin
          wr_char_en  = 1'b1;
          wr_color_en = 1'b1;
          wr_char     = CH_SPACE;
        end
        WR_ZERO_LEFT: begin
          wr_char_en = 1'b1;
          wr_addr    = cur_addr - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_char_en) begin
      char_mem[wr_addr] <= wr_char;
    end
    if (wr_color_en) begin
      color_mem[wr_addr] <= wr_color;
    end
    if (rd_en) begin
      rd_char_r  <= char_mem[rd_addr];
      rd_color_r <= color_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_hit_r <= 1'b0;
    end else if (cmd_i.rd_issue) begin
      rd_hit_r <= 1'b1;
    end
  end

  // result register
  assign lin_ext = (ADDR_W + LIN_W)'(cur_addr);
  assign col_ext = (COL_W + OCOL_W)'(col_r);
  assign row_ext = (ROW_W + OROW_W)'(row_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.out_load) begin
      out_col_r   <= col_ext[OCOL_W-1:0];
      out_row_r   <= row_ext[OROW_W-1:0];
      out_lin_r   <= lin_ext[LIN_W-1:0];
      out_char_r  <= rd_hit_r ? rd_char_r : CH_NULL;
      out_color_r <= rd_hit_r ? rd_color_r : '0;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.cursor_col    = out_col_r;
  assign out_chan.cursor_row    = out_row_r;
  assign out_chan.cursor_linear = out_lin_r;
  assign out_chan.cell_char     = out_char_r;
  assign out_chan.cell_color    = out_color_r;

  always_comb begin
    sts_o             = '0;
    sts_o.in_valid    = in_chan.valid;
    sts_o.act         = req_act_r;
    sts_o.chr         = chr;
    sts_o.col_zero    = (col_r == '0);
    sts_o.col_last    = col_last;
    sts_o.row_last    = row_last;
    sts_o.rd_in_range = (32'(req_row_r) < ROWS) && (32'(req_col_r) < COLUMNS);
    sts_o.tab_zero    = (tab_cnt_r == '0);
    sts_o.tab_last    = (tab_cnt_r == TC_W'(1));
    sts_o.sweep_last  = (sweep_r == ADDR_W'(CELLS - 1));
    sts_o.out_free    = !out_valid_r || out_chan.ready;
  end

`ifndef SYNTHESIS
  a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
    sw_wr_r |-> (cmd_i.wr_op == WR_NONE))
    else $error("cursor write collides with sweep write");

  a_cursor_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(col_r) < COLUMNS) && (32'(row_r) < ROWS))
    else $error("cursor outside the grid");

  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.out_load |-> (!out_valid_r || out_chan.ready))
    else $error("result loaded over an untaken result");
`endif

endmodule

// ===== hdl/tccw_ctrl.sv =====
// ----------------------------------------------------------------------------
// tccw_ctrl
// Sequencer for one request: decode, tab steps, sweeps and result hand-off.
// ----------------------------------------------------------------------------
module tccw_ctrl import tccw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  tccw_sts_t sts_i,
  output tccw_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_TAB   = 6'b000100,
    S_SWEEP = 6'b001000,
    S_DRAIN = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   wrap_scroll;

  // a put in the bottom right cell wraps into a scroll
  assign wrap_scroll = sts_i.col_last && sts_i.row_last;

  always_comb begin
    cmd_o     = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        unique case (sts_i.act)
          ACT_PUT: begin
            unique case (sts_i.chr)
              CC_PLAIN: begin
                cmd_o.wr_op  = WR_REQ_CHAR;
                cmd_o.cur_op = sts_i.col_last ? CUR_NEXT_LINE : CUR_NEXT_COL;
                if (wrap_scroll) begin
                  cmd_o.sweep_start = 1'b1;
                  cmd_o.sweep_mode  = SW_SCROLL;
                  state_nxt         = S_SWEEP;
                end
              end
              CC_NEWLINE: begin
                if (sts_i.col_zero) begin
                  cmd_o.wr_op = WR_NL_CELL;
                end
                cmd_o.cur_op = CUR_NEXT_LINE;
                if (sts_i.row_last) begin
                  cmd_o.sweep_start = 1'b1;
                  cmd_o.sweep_mode  = SW_SCROLL;
                  state_nxt         = S_SWEEP;
                end
              end
              CC_RETURN: begin
                cmd_o.cur_op = CUR_RETURN;
              end
              CC_TAB: begin
                cmd_o.tab_load = 1'b1;
                state_nxt      = S_TAB;
              end
              default: begin
              end
            endcase
          end
          ACT_CLEAR: begin
            cmd_o.cur_op      = CUR_HOME;
            cmd_o.sweep_start = 1'b1;
            cmd_o.sweep_mode  = SW_CLEAR;
            state_nxt         = S_SWEEP;
          end
          ACT_BACK: begin
            if (!sts_i.col_zero) begin
              cmd_o.wr_op  = WR_ZERO_LEFT;
              cmd_o.cur_op = CUR_BACK;
            end
          end
          ACT_READ: begin
            cmd_o.rd_issue = sts_i.rd_in_range;
          end
          default: begin
          end
        endcase
      end
      S_TAB: begin
        cmd_o.wr_op   = WR_SPACE_CHAR;
        cmd_o.cur_op  = sts_i.col_last ? CUR_NEXT_LINE : CUR_NEXT_COL;
        cmd_o.tab_dec = 1'b1;
        if (wrap_scroll) begin
          cmd_o.sweep_start = 1'b1;
          cmd_o.sweep_mode  = SW_SCROLL;
          state_nxt         = S_SWEEP;
        end else if (sts_i.tab_last) begin
          state_nxt = S_DONE;
        end
      end
      S_SWEEP: begin
        cmd_o.sweep_run = 1'b1;
        if (sts_i.sweep_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = sts_i.tab_zero ? S_DONE : S_TAB;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_tab_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TAB) |-> !sts_i.tab_zero)
    else $error("tab step with no spaces left");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (sts_i.in_valid && cmd_o.in_ready) |=> (state_r == S_EXEC))
    else $error("accepted request not decoded next cycle");

  a_sweep_follows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.sweep_start |=> (state_r == S_SWEEP) && cmd_o.sweep_run)
    else $error("sweep started but not run");
`endif

endmodule

// ===== hdl/text_console_char_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_char_writer
// Text console engine: character and colour cell grid with a cursor.
// ----------------------------------------------------------------------------
//
//   port      direction  handshake        carries
//   in_chan   sink       valid / ready    one request: action, char_code, read cell
//   out_chan  source     valid / ready    one result per request: cursor, read cell
//   cfg_*     sink       cfg_wr_en only   blank colour attribute
//
// sequence: plain put, return, newline, backspace and read go from accept
//   through execute to result load; a tab adds a step that writes each space
// a scroll or clear walks all ROWS*COLUMNS cells of the memory one a cycle,
//   as the single memory write port takes one cell write at a time
// reset clears the cursor, the controller and the blank colour (to 7); the cell
//   memory has no clearing pass and holds nothing defined until a clear
// a stalled result holds in the output register while the next request is
//   accepted; that request then waits at result load until the slot frees
// ----------------------------------------------------------------------------
module text_console_char_writer import tccw_pkg::*; #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [COLOR_W-1:0] cfg_wr_data,
  tccw_req_if.sink           in_chan,
  tccw_rsp_if.source         out_chan
);

  // command and status buses between sequencer and datapath
  tccw_cmd_t cmd;
  tccw_sts_t sts;

  // sequencer: decodes each request, steps tabs, runs sweeps
  tccw_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts_i (sts),
    .cmd_o (cmd)
  );

  // datapath: cell memories, cursor, sweep pipeline, result register
  tccw_datapath #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
